[rtl/core/fbbe_pkg.sv]
// ----------------------------------------------------------------------------
// fbbe_pkg
// Shared types and constants of the byte budget evictor: request and result
// payloads, ring entry, saturating unit codes and budget limits.
// ----------------------------------------------------------------------------
package fbbe_pkg;

  // Budget limits in bytes and the default ring depth in entries.
  localparam int unsigned CapDefault       = 96 * 1024 * 1024;
  localparam int unsigned CapMin           = 16 * 1024 * 1024;
  localparam int unsigned CapMax           = 1024 * 1024 * 1024;
  localparam int unsigned RingDepthDefault = 32;

  // Request opcodes.
  localparam logic OpReserve = 1'b0;
  localparam logic OpCommit  = 1'b1;

  // Operations of the shared saturating unit.
  typedef enum logic {
    AluAdd,
    AluSub
  } alu_op_e;

  // Output of the shared saturating unit.
  typedef struct packed {
    logic signed [31:0] sum;
    logic               negative;
  } alu_res_t;

  // One ring entry.
  typedef struct packed {
    logic [31:0] tag;
    logic [30:0] size;
  } entry_t;

  // One request.
  typedef struct packed {
    logic        opcode;
    logic [30:0] request_size;
    logic [31:0] entry_tag;
  } req_t;

  // One result.
  typedef struct packed {
    logic               is_eviction;
    logic [31:0]        evicted_tag;
    logic [30:0]        evicted_size;
    logic signed [31:0] available_bytes;
    logic               last;
  } res_t;

endpackage

[rtl/core/fbbe_ring.sv]
// ----------------------------------------------------------------------------
// fbbe_ring
// Ring storage of cached entries: one write port and one registered read port.
// ----------------------------------------------------------------------------
module fbbe_ring #(
  parameter int unsigned RING_DEPTH = fbbe_pkg::RingDepthDefault,
  localparam int unsigned IdxW      = $clog2(RING_DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [IdxW-1:0]      wr_addr_i,
  input  fbbe_pkg::entry_t     wr_entry_i,
  input  logic                 rd_en_i,
  input  logic [IdxW-1:0]      rd_addr_i,
  output fbbe_pkg::entry_t     rd_entry_o
);
  import fbbe_pkg::*;

  entry_t mem_q [RING_DEPTH];
  entry_t rd_entry_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_entry_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_entry_o = rd_entry_q;

endmodule

[rtl/core/fbbe_alu.sv]
// ----------------------------------------------------------------------------
// fbbe_alu
// Shared saturating adder and subtractor for the available byte count; the
// exact sign of the difference also serves as the fit test of a reserve.
// ----------------------------------------------------------------------------
module fbbe_alu (
  input  logic signed [31:0]  avail_i,
  input  logic [30:0]         operand_i,
  input  fbbe_pkg::alu_op_e   op_i,
  output fbbe_pkg::alu_res_t  res_o
);
  import fbbe_pkg::*;

  logic signed [32:0] a_ext;
  logic signed [32:0] b_ext;
  logic signed [32:0] exact;

  // Exact 33-bit result of the operation.
  always_comb begin
    a_ext = {avail_i[31], avail_i};
    b_ext = {2'b00, operand_i};
    case (op_i)
      AluAdd:  exact = a_ext + b_ext;
      default: exact = a_ext - b_ext;
    endcase
  end

  // Saturate to the signed 32-bit range.
  always_comb begin
    if (exact[32:31] == 2'b01) begin
      res_o.sum = 32'sh7FFF_FFFF;
    end else if (exact[32:31] == 2'b10) begin
      res_o.sum = 32'sh8000_0000;
    end else begin
      res_o.sum = exact[31:0];
    end
    res_o.negative = exact[32];
  end

endmodule

[rtl/core/fifo_byte_budget_evictor.sv]
// ----------------------------------------------------------------------------
// fifo_byte_budget_evictor
// Byte budget cache bookkeeping with oldest-first eviction over a ring.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the request has finished. A commit runs commit and status states,
// with an evict state between when it fills the ring and evicts the oldest
// entry. A reserve runs check and status; per eviction, a check for the
// fit test and ring read and an evict for the add, in one shared saturating
// unit. Every result appears for exactly one cycle with res_valid_o high, the
// final status result with last set, and it must be taken then, as the block
// has no means to hold it. Writing the capacity takes effect at once, reloads
// the available count (an out-of-range value loads the default) and empties
// the ring; it is meant only while busy is low.
// ----------------------------------------------------------------------------
module fifo_byte_budget_evictor #(
  parameter int unsigned RING_DEPTH = fbbe_pkg::RingDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  fbbe_pkg::req_t  req_i,
  output logic            res_valid_o,
  output fbbe_pkg::res_t  res_o,
  input  logic            cfg_we_i,
  input  logic [30:0]     cfg_wdata_i
);
  import fbbe_pkg::*;

  localparam int unsigned IdxW = $clog2(RING_DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(RING_DEPTH - 1);

  typedef enum logic [2:0] {
    StIdle,
    StCommit,
    StCheck,
    StEvict,
    StStatus
  } state_e;

  state_e             state_q, state_d;
  logic [IdxW-1:0]    head_q, head_d;
  logic [IdxW-1:0]    tail_q, tail_d;
  logic signed [31:0] avail_q, avail_d;
  req_t               req_q, req_d;
  res_t               res_q, res_d;
  logic               res_valid_q, res_valid_d;

  logic [IdxW-1:0]    head_nxt;
  logic [IdxW-1:0]    tail_nxt;
  logic               wr_en;
  logic               rd_en;
  entry_t             wr_entry;
  entry_t             rd_entry;
  alu_op_e            alu_op;
  logic [30:0]        alu_operand;
  alu_res_t           alu_res;
  logic [30:0]        cap_load;

  // Ring storage.
  fbbe_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (head_q),
    .wr_entry_i (wr_entry),
    .rd_en_i    (rd_en),
    .rd_addr_i  (tail_q),
    .rd_entry_o (rd_entry)
  );

  // Shared saturating unit.
  fbbe_alu u_alu (
    .avail_i   (avail_q),
    .operand_i (alu_operand),
    .op_i      (alu_op),
    .res_o     (alu_res)
  );

  // Ring pointer increments with wrap.
  assign head_nxt = (head_q == LastIdx) ? '0 : head_q + 1'b1;
  assign tail_nxt = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;

  assign wr_entry.tag  = req_q.entry_tag;
  assign wr_entry.size = req_q.request_size;

  // Capacity value with the out-of-range case replaced by the default.
  assign cap_load = ((cfg_wdata_i < 31'(CapMin)) || (cfg_wdata_i > 31'(CapMax)))
                    ? 31'(CapDefault) : cfg_wdata_i;

  // Sequencer next state.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    avail_d     = avail_q;
    req_d       = req_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    alu_op      = AluSub;
    alu_operand = req_q.request_size;

    unique case (state_q)
      StIdle: begin
        if (start) begin
          req_d   = req_i;
          state_d = (req_i.opcode == OpCommit) ? StCommit : StCheck;
        end
      end
      StCommit: begin
        avail_d = alu_res.sum;
        wr_en   = 1'b1;
        head_d  = head_nxt;
        if (head_nxt == tail_q) begin
          rd_en   = 1'b1;
          state_d = StEvict;
        end else begin
          state_d = StStatus;
        end
      end
      StCheck: begin
        if (alu_res.negative && (head_q != tail_q)) begin
          rd_en   = 1'b1;
          state_d = StEvict;
        end else begin
          state_d = StStatus;
        end
      end
      StEvict: begin
        alu_op                = AluAdd;
        alu_operand           = rd_entry.size;
        avail_d               = alu_res.sum;
        tail_d                = tail_nxt;
        res_d.is_eviction     = 1'b1;
        res_d.evicted_tag     = rd_entry.tag;
        res_d.evicted_size    = rd_entry.size;
        res_d.available_bytes = alu_res.sum;
        res_d.last            = 1'b0;
        res_valid_d           = 1'b1;
        state_d               = (req_q.opcode == OpCommit) ? StStatus : StCheck;
      end
      StStatus: begin
        res_d.is_eviction     = 1'b0;
        res_d.evicted_tag     = '0;
        res_d.evicted_size    = '0;
        res_d.available_bytes = avail_q;
        res_d.last            = 1'b1;
        res_valid_d           = 1'b1;
        state_d               = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // A capacity write empties the ring and reloads the budget.
    if (cfg_we_i) begin
      head_d  = '0;
      tail_d  = '0;
      avail_d = {1'b0, cap_load};
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      tail_q      <= '0;
      avail_q     <= 32'(CapDefault);
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      avail_q     <= avail_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

  assign busy        = (state_q != StIdle);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // The final status result leaves the block ready for the next request.
  a_status_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |-> !busy)
    else $error("status result delivered while still busy");

  // An accepted request always holds the block busy for its work.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted without going busy");

  // Every result other than the final one reports an eviction.
  a_mid_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> res_o.is_eviction)
    else $error("non-final result is not an eviction");

  // Evictions only occur inside a request, never between requests.
  a_evict_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.is_eviction |-> busy && !res_o.last)
    else $error("eviction result outside a request");

endmodule
